>>> sv/tssd_pkg.sv
// Shared types, codes and constants for the temperature seven-segment display.
package tssd_pkg;

    localparam int DIGITS     = 4;
    localparam int CODE_W     = 4;
    localparam int POS_W      = 2;
    localparam int SAMPLE_W   = 16;
    localparam int SEG_W      = 8;
    localparam int TICK_W     = 8;
    localparam int MAG_W      = 12;
    localparam int Q1_W       = 9;
    localparam int Q2_W       = 5;

    // digit codes
    localparam logic [CODE_W-1:0] CODE_MINUS = 4'd10;
    localparam logic [CODE_W-1:0] CODE_BLANK = 4'd11;

    // operations
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // configuration register indexes
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TICKS = 1'd1;
    localparam logic [TICK_W-1:0]    TICKS_RESET = 8'd3;

    // digit positions
    localparam logic [POS_W-1:0] POINT_POS = 2'd1;

    // divide by ten: x * 52429 >> 19 (exact for 16-bit x), x * 205 >> 11 (exact below 1029)
    localparam logic [16:0] DIV10_MUL    = 17'd52429;
    localparam int          DIV10_SHIFT  = 19;
    localparam logic [7:0]  DIV10S_MUL   = 8'd205;
    localparam int          DIV10S_SHIFT = 11;

    localparam int Q_DEPTH = 4;

    typedef logic [DIGITS-1:0][CODE_W-1:0] t_codes;

    typedef struct packed {
        logic   op;
        t_codes codes;
    } t_qword;

    function automatic logic [6:0] seg_pattern(input logic [CODE_W-1:0] code);
        logic [6:0] pat;
        case (code)
            4'd0:       pat = 7'h3f;
            4'd1:       pat = 7'h06;
            4'd2:       pat = 7'h5b;
            4'd3:       pat = 7'h4f;
            4'd4:       pat = 7'h66;
            4'd5:       pat = 7'h6d;
            4'd6:       pat = 7'h7c;
            4'd7:       pat = 7'h07;
            4'd8:       pat = 7'h7f;
            4'd9:       pat = 7'h67;
            CODE_MINUS: pat = 7'h40;
            default:    pat = 7'h00;
        endcase
        return pat;
    endfunction

endpackage

>>> sv/tssd_in_if.sv
// Input channel: operation and raw sensor word.
interface tssd_in_if import tssd_pkg::*; ();
    logic                valid;
    logic                ready;
    logic                operation;
    logic [SAMPLE_W-1:0] sample;

    modport source (output valid, output operation, output sample, input ready);
    modport sink   (input valid, input operation, input sample, output ready);
endinterface

>>> sv/tssd_out_if.sv
// Output channel: segment pattern and digit select.
interface tssd_out_if import tssd_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [SEG_W-1:0]  segments;
    logic [DIGITS-1:0] digit_select;

    modport source (output valid, output segments, output digit_select, input ready);
    modport sink   (input valid, input segments, input digit_select, output ready);
endinterface

>>> sv/tssd_front.sv
// Front end: four-stage conversion of a sensor word to digit codes.
module tssd_front import tssd_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_fahrenheit_mode,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic                i_operation,
    input  logic [SAMPLE_W-1:0] i_sample,
    output logic                o_valid,
    input  logic                i_ready,
    output t_qword              o_word
);

    logic en;

    // stage 1: value in tenths, sign and magnitude
    logic signed [8:0]  w_t;
    logic signed [12:0] w_t13;
    logic signed [12:0] w_val;
    logic signed [12:0] w_abs;
    logic               w_neg;

    logic             r_v1, r_op1, r_neg1;
    logic [MAG_W-1:0] r_mag1;

    // stage 2: quotient by ten
    logic [28:0]      w_prod2;
    logic             r_v2, r_op2, r_neg2;
    logic [MAG_W-1:0] r_mag2;
    logic [Q1_W-1:0]  r_q1_2;

    // stage 3: tenths digit, quotient by hundred
    logic [MAG_W-1:0] w_q1x10;
    logic [MAG_W-1:0] w_r0;
    logic [16:0]      w_prod3;
    logic             r_v3, r_op3, r_neg3;
    logic [3:0]       r_r0_3;
    logic [Q1_W-1:0]  r_q1_3;
    logic [Q2_W-1:0]  r_q2_3;

    // stage 4: ones and tens digits
    logic [Q1_W-1:0]  w_q2x10;
    logic [Q1_W-1:0]  w_r1;
    logic [Q2_W-1:0]  w_tens;
    logic             r_v4;
    t_qword           r_word4;
    t_qword           n_word4;

    assign en      = !r_v4 || i_ready;
    assign o_ready = en;
    assign o_valid = r_v4;
    assign o_word  = r_word4;

    always_comb begin
        w_t   = $signed(i_sample[15:7]);
        w_t13 = 13'(w_t);
        if (i_fahrenheit_mode) begin
            w_val = 13'sd320 + (w_t13 <<< 3) + w_t13;
        end else begin
            w_val = (w_t13 <<< 2) + w_t13;
        end
        w_neg = w_val[12];
        w_abs = w_neg ? -w_val : w_val;
    end

    assign w_prod2 = {17'd0, r_mag1} * {12'd0, DIV10_MUL};

    assign w_q1x10 = {r_q1_2, 3'b000} + {2'b00, r_q1_2, 1'b0};
    assign w_r0    = r_mag2 - w_q1x10;
    assign w_prod3 = {8'd0, r_q1_2} * {9'd0, DIV10S_MUL};

    always_comb begin
        w_q2x10 = {1'b0, r_q2_3, 3'b000} + {3'b000, r_q2_3, 1'b0};
        w_r1    = r_q1_3 - w_q2x10;
        if (r_q2_3 >= 5'd20) begin
            w_tens = r_q2_3 - 5'd20;
        end else if (r_q2_3 >= 5'd10) begin
            w_tens = r_q2_3 - 5'd10;
        end else begin
            w_tens = r_q2_3;
        end
        n_word4.op       = r_op3;
        n_word4.codes[0] = r_r0_3;
        n_word4.codes[1] = w_r1[3:0];
        n_word4.codes[2] = w_tens[3:0];
        n_word4.codes[3] = r_neg3 ? CODE_MINUS : CODE_BLANK;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else if (en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_op1   <= i_operation;
            r_neg1  <= w_neg;
            r_mag1  <= w_abs[MAG_W-1:0];

            r_op2   <= r_op1;
            r_neg2  <= r_neg1;
            r_mag2  <= r_mag1;
            r_q1_2  <= w_prod2[DIV10_SHIFT+Q1_W-1:DIV10_SHIFT];

            r_op3   <= r_op2;
            r_neg3  <= r_neg2;
            r_r0_3  <= w_r0[3:0];
            r_q1_3  <= r_q1_2;
            r_q2_3  <= w_prod3[DIV10S_SHIFT+Q2_W-1:DIV10S_SHIFT];

            r_word4 <= n_word4;
        end
    end

    // converted load words carry decimal digits in the three positions below the sign
    a_digits_decimal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v4 && r_word4.op == OP_LOAD) |->
            (r_word4.codes[0] <= 4'd9 && r_word4.codes[1] <= 4'd9 &&
             r_word4.codes[2] <= 4'd9))
        else $error("front: non-decimal digit in converted word");

endmodule

>>> sv/tssd_queue.sv
// Short word queue between front and back.
module tssd_queue import tssd_pkg::*; #(
    parameter int DEPTH = Q_DEPTH
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_valid,
    output logic   o_ready,
    input  t_qword i_word,
    output logic   o_valid,
    input  logic   i_ready,
    output t_qword o_word
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_qword           r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             push, pop;

    assign o_ready = r_count != CNT_W'(DEPTH);
    assign o_valid = r_count != '0;
    assign o_word  = r_mem[r_rd_ptr];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    a_count_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !pop) |=> r_count == $past(r_count) + 1'b1)
        else $error("queue: fill count lost a push");

    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("queue: fill count above depth");

endmodule

>>> sv/tssd_back.sv
// Back end: digit code store, scan counter and registered display word.
module tssd_back import tssd_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [TICK_W-1:0] i_ticks_per_digit,
    input  logic              i_valid,
    output logic              o_ready,
    input  t_qword            i_word,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [SEG_W-1:0]  o_segments,
    output logic [DIGITS-1:0] o_digit_select
);

    t_codes            r_codes, n_codes;
    logic [POS_W-1:0]  r_scan, n_scan;
    logic [TICK_W-1:0] r_tick, n_tick;
    logic [TICK_W:0]   w_next;
    logic              pop;
    logic [SEG_W-1:0]  n_segments;

    logic              r_out_valid;
    logic [SEG_W-1:0]  r_segments;
    logic [DIGITS-1:0] r_digit_select;

    assign o_ready        = !r_out_valid || i_ready;
    assign pop            = i_valid && o_ready;
    assign o_valid        = r_out_valid;
    assign o_segments     = r_segments;
    assign o_digit_select = r_digit_select;

    always_comb begin
        n_codes = r_codes;
        n_scan  = r_scan;
        n_tick  = r_tick;
        w_next  = {1'b0, r_tick} + 1'b1;
        if (i_word.op == OP_LOAD) begin
            n_codes = i_word.codes;
        end else if (w_next >= {1'b0, i_ticks_per_digit}) begin
            n_tick = '0;
            n_scan = r_scan + 1'b1;
        end else begin
            n_tick = w_next[TICK_W-1:0];
        end
        n_segments = {(n_scan == POINT_POS), seg_pattern(n_codes[n_scan])};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_codes     <= {DIGITS{CODE_BLANK}};
            r_scan      <= '0;
            r_tick      <= '0;
            r_out_valid <= 1'b0;
        end else if (pop) begin
            r_codes     <= n_codes;
            r_scan      <= n_scan;
            r_tick      <= n_tick;
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_segments     <= n_segments;
            r_digit_select <= DIGITS'(1) << n_scan;
        end
    end

    a_select_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> $onehot(r_digit_select))
        else $error("back: digit select not one-hot");

    a_point_on_ones: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_segments[SEG_W-1] == r_digit_select[POINT_POS]))
        else $error("back: decimal point off the ones digit");

    a_select_tracks_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |=> r_digit_select[r_scan])
        else $error("back: shown digit differs from scan position");

endmodule

>>> sv/temperature_seven_segment_display.sv
// Path: a word accepted on the input passes 4 conversion stages, one queue slot and
// one output register before it shows on the output.
// Throughput: one word per cycle; the front pipeline, queue and back end each stall
// on their own and the 4-entry queue soaks up short output stalls.
// Reset (i_rst_n low at a clock edge): all digits blank, scan on the tenths digit,
// tick count zero, Celsius mode, 3 ticks per digit; pipeline and queue emptied.
module temperature_seven_segment_display import tssd_pkg::*; #(
    parameter int QUEUE_DEPTH = Q_DEPTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    tssd_in_if.sink               i_word,
    tssd_out_if.source            o_word
);

    // Config registers. Mode is sampled by the front end when a load enters, the tick
    // period by the back end when a tick is applied. The user must rewrite both only while
    // the block is idle, so no word sees a half-updated pair; the block doesn't enforce it.
    logic              r_fahrenheit_mode;
    logic [TICK_W-1:0] r_ticks_per_digit;

    // front -> queue
    logic   front_valid, front_ready;
    t_qword front_word;

    // queue -> back
    logic   q_valid, q_ready;
    t_qword q_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fahrenheit_mode <= 1'b0;
            r_ticks_per_digit <= TICKS_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MODE:  r_fahrenheit_mode <= i_cfg_data[0];
                CFG_TICKS: r_ticks_per_digit <= i_cfg_data[TICK_W-1:0];
                default: ;
            endcase
        end
    end

    // Front: sign/magnitude in tenths of a degree (5*t for Celsius, 320+9*t for
    // Fahrenheit), then two reciprocal multiplies split it into decimal digits.
    // Ticks ride along unconverted so words stay in order.
    tssd_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_fahrenheit_mode (r_fahrenheit_mode),
        .i_valid           (i_word.valid),
        .o_ready           (i_word.ready),
        .i_operation       (i_word.operation),
        .i_sample          (i_word.sample),
        .o_valid           (front_valid),
        .i_ready           (front_ready),
        .o_word            (front_word)
    );

    // Decouples the conversion pipeline from the display side.
    tssd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (front_valid),
        .o_ready (front_ready),
        .i_word  (front_word),
        .o_valid (q_valid),
        .i_ready (q_ready),
        .o_word  (q_word)
    );

    // Back: a load replaces the stored codes, a tick steps the tick count and, on wrap,
    // the scan counter; either way the lit digit's pattern goes to the output register.
    tssd_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_ticks_per_digit (r_ticks_per_digit),
        .i_valid           (q_valid),
        .o_ready           (q_ready),
        .i_word            (q_word),
        .o_valid           (o_word.valid),
        .i_ready           (o_word.ready),
        .o_segments        (o_word.segments),
        .o_digit_select    (o_word.digit_select)
    );

endmodule

>>> tb/tssd_checker.sv
// Checker for the temperature display: tracks register writes and words, predicts, compares.
`timescale 1ns / 1ps

module tssd_checker import tssd_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    tssd_in_if                    in_ch,
    tssd_out_if                   out_ch,
    output int                    o_errors,
    output int                    o_pending
);

    typedef struct packed {
        logic [SEG_W-1:0]  segments;
        logic [DIGITS-1:0] digit_select;
    } t_shown;

    // predictor state
    logic                fahr_mode;
    logic [TICK_W-1:0]   period;
    logic [CODE_W-1:0]   digit_code [DIGITS];
    logic [POS_W-1:0]    lit_pos;
    logic [TICK_W-1:0]   tick_cnt;

    t_shown shown_q [$];
    int     err_cnt = 0;

    function automatic logic [6:0] glyph(input logic [CODE_W-1:0] code);
        logic [6:0] g;
        case (code)
            4'd0:       g = 7'h3f;
            4'd1:       g = 7'h06;
            4'd2:       g = 7'h5b;
            4'd3:       g = 7'h4f;
            4'd4:       g = 7'h66;
            4'd5:       g = 7'h6d;
            4'd6:       g = 7'h7c;
            4'd7:       g = 7'h07;
            4'd8:       g = 7'h7f;
            4'd9:       g = 7'h67;
            CODE_MINUS: g = 7'h40;
            default:    g = 7'h00;
        endcase
        return g;
    endfunction

    // one word: update the codes or the scan, return what the display shows
    function automatic t_shown step_display(input logic op, input logic [SAMPLE_W-1:0] raw);
        logic signed [8:0] half;
        int                t;
        int                f;
        int                mag;
        int                deg;
        t_shown            d;
        if (op == OP_LOAD) begin
            half = raw[15:7];
            t    = half;
            if (fahr_mode) begin
                f   = 320 + 9 * t;
                mag = (f < 0) ? -f : f;
                digit_code[0] = CODE_W'(mag % 10);
                digit_code[1] = CODE_W'((mag / 10) % 10);
                digit_code[2] = CODE_W'((mag / 100) % 10);
                digit_code[3] = (f < 0) ? CODE_MINUS : CODE_BLANK;
            end else begin
                mag = (t < 0) ? -t : t;
                deg = mag >> 1;
                digit_code[0] = (mag % 2 != 0) ? 4'd5 : 4'd0;
                digit_code[1] = CODE_W'(deg % 10);
                digit_code[2] = CODE_W'((deg / 10) % 10);
                digit_code[3] = (t < 0) ? CODE_MINUS : CODE_BLANK;
            end
        end else begin
            if (int'(tick_cnt) + 1 >= int'(period)) begin
                tick_cnt = '0;
                lit_pos  = lit_pos + 1'b1;
            end else begin
                tick_cnt = tick_cnt + 1'b1;
            end
        end
        d.segments     = {lit_pos == POINT_POS, glyph(digit_code[lit_pos])};
        d.digit_select = DIGITS'(1) << lit_pos;
        return d;
    endfunction

    task automatic report(input string msg);
        $display("%0t ns: mismatch: %s", $time, msg);
        err_cnt++;
    endtask

    always @(posedge i_clk) begin
        t_shown got;
        t_shown want;
        if (!i_rst_n) begin
            fahr_mode = 1'b0;
            period    = TICKS_RESET;
            for (int i = 0; i < DIGITS; i++) digit_code[i] = CODE_BLANK;
            lit_pos   = '0;
            tick_cnt  = '0;
            shown_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_MODE:  fahr_mode = i_cfg_data[0];
                    CFG_TICKS: period    = i_cfg_data;
                    default: ;
                endcase
            end
            if (in_ch.valid && in_ch.ready)
                shown_q.push_back(step_display(in_ch.operation, in_ch.sample));
            if (out_ch.valid && out_ch.ready) begin
                got.segments     = out_ch.segments;
                got.digit_select = out_ch.digit_select;
                if (shown_q.size() == 0) begin
                    report($sformatf("unexpected word seg=%h sel=%b",
                                     got.segments, got.digit_select));
                end else begin
                    want = shown_q.pop_front();
                    if (got.segments !== want.segments)
                        report($sformatf("segments %h, want %h",
                                         got.segments, want.segments));
                    if (got.digit_select !== want.digit_select)
                        report($sformatf("digit_select %b, want %b",
                                         got.digit_select, want.digit_select));
                end
            end
        end
        o_pending <= shown_q.size();
    end

    assign o_errors = err_cnt;

endmodule

>>> tb/tb_top.sv
// Top of the temperature display testbench: clock, reset, register writes, stimulus, verdict.
`timescale 1ns / 1ps

module tb_top import tssd_pkg::*; ();

    localparam int  SETTLE_CYCLES = 10;      // longer than the block's input-to-output latency
    localparam int  DRAIN_LIMIT   = 50000;   // cycles to wait for outstanding words
    localparam int  RAND_PHASES   = 8;
    localparam int  PHASE_WORDS   = 64;      // 8 x 64 = 512 random words
    localparam time WATCHDOG_NS   = 2ms;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    int errors;
    int pending;

    // percent of cycles the sender idles and the receiver stalls
    int send_idle_pct = 0;
    int stall_pct     = 0;

    tssd_in_if  in_ch ();
    tssd_out_if out_ch ();

    temperature_seven_segment_display dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_word     (in_ch),
        .o_word     (out_ch)
    );

    tssd_checker chk (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .in_ch      (in_ch),
        .out_ch     (out_ch),
        .o_errors   (errors),
        .o_pending  (pending)
    );

    // 4 ns clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Receiver: ready redrawn every falling edge from the current stall rate.
    initial begin
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            out_ch.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Hard stop in case the block hangs.
    initial begin
        #(WATCHDOG_NS);
        $display("*** FAILED ***");
        $finish;
    end

    // Raw sensor word for a temperature in half degrees; low 7 bits left zero.
    function automatic logic [SAMPLE_W-1:0] raw_of(input int half_deg);
        return {9'(half_deg), 7'd0};
    endfunction

    // Idle pattern per phase: none, sender mostly idle, receiver mostly stalled, both light.
    task automatic set_pressure(input int kind);
        case (kind % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 88; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 88; end
            default: begin send_idle_pct = 9; stall_pct = 9; end
        endcase
    endtask

    // Offer one word. Valid stays high on return so back-to-back words need no
    // drop; an idle gap lowers it at a later falling edge.
    task automatic send_word(input logic op, input logic [SAMPLE_W-1:0] raw);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.operation <= op;
        in_ch.sample    <= raw;
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    task automatic tick_n(input int n);
        repeat (n) send_word(OP_TICK, 16'($urandom_range(65535)));
    endtask

    // Drop valid, wait for every predicted word to come out, then let the
    // pipeline run dry before anything touches the registers.
    task automatic settle();
        int n;
        n = 0;
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        while (pending != 0 && n < DRAIN_LIMIT) begin
            @(negedge i_clk);
            n++;
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(negedge i_clk);
        cfg_we   <= 1'b0;
    endtask

    // Random sample: extremes, the Fahrenheit zero crossing, small values, or anything.
    function automatic logic [SAMPLE_W-1:0] pick_sample();
        logic [6:0] junk;
        junk = 7'($urandom_range(127));
        case ($urandom_range(9))
            0:       return {9'h0ff, junk};
            1:       return {9'h100, junk};
            2:       return {9'($urandom_range(40) - 56), junk};
            3:       return {9'($urandom_range(40) - 20), junk};
            default: return 16'($urandom_range(65535));
        endcase
    endfunction

    function automatic logic [TICK_W-1:0] pick_period();
        case ($urandom_range(7))
            0:       return 8'd0;
            1:       return 8'd255;
            2:       return 8'($urandom_range(255));
            default: return 8'($urandom_range(4, 1));
        endcase
    endfunction

    initial begin
        // every input known from time zero
        i_rst_n         = 1'b0;
        cfg_we          = 1'b0;
        cfg_idx         = CFG_MODE;
        cfg_data        = '0;
        in_ch.valid     = 1'b0;
        in_ch.operation = OP_TICK;
        in_ch.sample    = '0;

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // ---- directed: reset settings, Celsius, 3 ticks per digit ----
        set_pressure(3);
        tick_n(3);                          // blank display, scan lands on ones: point only
        send_word(OP_LOAD, raw_of(0));      // load keeps the scan, shows the new ones digit
        send_word(OP_LOAD, 16'h7f80);       // +127.5: hundreds dropped
        tick_n(3);                          // onto tens
        send_word(OP_LOAD, 16'h8000);       // -128.0
        tick_n(3);                          // onto sign: minus
        send_word(OP_LOAD, 16'hffff);       // -0.5, low bits must be ignored
        send_word(OP_LOAD, 16'h0080);       // +0.5, sign goes blank
        tick_n(3);                          // wrap back to tenths

        // ---- Fahrenheit, one tick per digit ----
        settle();
        write_reg(CFG_MODE, 8'h01);
        write_reg(CFG_TICKS, 8'd1);
        send_word(OP_LOAD, raw_of(-36));    // -0.4 F: sign follows the result
        tick_n(3);
        send_word(OP_LOAD, raw_of(-35));    // +0.5 F
        send_word(OP_LOAD, raw_of(-256));   // -198.4 F, hundreds dropped
        send_word(OP_LOAD, raw_of(255));    // 261.5 F

        // ---- period zero acts like one; mode change leaves stored codes alone ----
        settle();
        write_reg(CFG_TICKS, 8'd0);
        write_reg(CFG_MODE, 8'hfe);         // bit 0 clear: back to Celsius
        tick_n(2);

        // ---- period lowered while the count is already past it ----
        settle();
        write_reg(CFG_TICKS, 8'd255);
        tick_n(5);
        settle();
        write_reg(CFG_TICKS, 8'd2);
        tick_n(1);

        // ---- random phases: new settings and idle pattern each phase ----
        for (int p = 0; p < RAND_PHASES; p++) begin
            settle();
            write_reg(CFG_MODE, {7'($urandom_range(127)), 1'($urandom_range(1))});
            write_reg(CFG_TICKS, pick_period());
            set_pressure(p);
            for (int k = 0; k < PHASE_WORDS; k++) begin
                if ($urandom_range(9) < 6)
                    send_word(OP_TICK, 16'($urandom_range(65535)));
                else
                    send_word(OP_LOAD, pick_sample());
            end
        end

        // drain with the receiver free-running a little
        set_pressure(3);
        settle();

        if (errors == 0 && pending == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

>>> sim.f
sv/tssd_pkg.sv
sv/tssd_in_if.sv
sv/tssd_out_if.sv
sv/tssd_front.sv
sv/tssd_queue.sv
sv/tssd_back.sv
sv/temperature_seven_segment_display.sv
tb/tssd_checker.sv
tb/tb_top.sv
